### hw/rtl/assert_macros.svh
// Assertion macros used by the solver top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property checked on every rising clk edge, off while arst_n is low.
`define KES_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Condition that must never be seen.
`define KES_ASSERT_NEVER(label, cond, msg) \
	`KES_ASSERT(label, !(cond), msg)
`endif

### hw/rtl/kes_pkg.sv
// Types, constants and coefficient tables of the Kepler equation solver.
package kes_pkg;

	typedef struct packed {
		logic signed [31:0] mean_anomaly;
		logic [27:0]        eccentricity;
	} item_t;

	typedef struct packed {
		logic signed [31:0] eccentric_anomaly;
		logic [4:0]         step_count;
		logic               converged;
	} result_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_AA = 3'd0,
		MUL_YT = 3'd1,
		MUL_NR = 3'd2,
		MUL_AT = 3'd3,
		MUL_ES = 3'd4,
		MUL_EC = 3'd5
	} mul_sel_t;

	typedef struct packed {
		logic       load;
		logic       fold;
		logic       mul_en;
		mul_sel_t   mul_sel;
		logic       lat_y;
		logic       lat_n;
		logic       hc;
		logic [3:0] kidx;
		logic       lat_sr;
		logic       quad;
		logic       lat_es;
		logic       lat_fd;
		logic       chk;
		logic       div;
		logic       div_first;
		logic       upd;
	} cmd_t;

	typedef struct packed {
		logic fold_done;
		logic big;
		logic finish;
	} status_t;

	localparam logic signed [34:0] QUARTER_PI = 35'sd843314856;
	localparam logic signed [34:0] HALF_PI    = 35'sd1686629713;
	localparam logic [30:0]        ONE30      = 31'h4000_0000;
	localparam logic [30:0]        Q_LIMIT    = 31'h2000_0000;
	localparam logic [27:0]        DQ_MAX     = 28'h800_0000;
	localparam logic [3:0]         SIN_FIRST  = 4'd0;
	localparam logic [3:0]         SIN_LAST   = 4'd4;
	localparam logic [3:0]         COS_FIRST  = 4'd5;
	localparam logic [3:0]         COS_LAST   = 4'd10;
	localparam logic [4:0]         DIV_LAST   = 5'd30;
	localparam logic               TOL_INDEX  = 1'b0;

	// Horner divisors: sine terms first, then cosine terms
	function automatic logic [7:0] horner_k(input logic [3:0] idx);
		logic [7:0] k;
		case (idx)
			4'd0:    k = 8'd110;
			4'd1:    k = 8'd72;
			4'd2:    k = 8'd42;
			4'd3:    k = 8'd20;
			4'd4:    k = 8'd6;
			4'd5:    k = 8'd132;
			4'd6:    k = 8'd90;
			4'd7:    k = 8'd56;
			4'd8:    k = 8'd30;
			4'd9:    k = 8'd12;
			4'd10:   k = 8'd2;
			default: k = 8'd2;
		endcase
		return k;
	endfunction

	// floor(2^32 / k) for the divisor of the same index
	function automatic logic [31:0] horner_r(input logic [3:0] idx);
		logic [31:0] r;
		case (idx)
			4'd0:    r = 32'd39045157;
			4'd1:    r = 32'd59652323;
			4'd2:    r = 32'd102261126;
			4'd3:    r = 32'd214748364;
			4'd4:    r = 32'd715827882;
			4'd5:    r = 32'd32537631;
			4'd6:    r = 32'd47721858;
			4'd7:    r = 32'd76695844;
			4'd8:    r = 32'd143165576;
			4'd9:    r = 32'd357913941;
			4'd10:   r = 32'd2147483648;
			default: r = 32'd2147483648;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/kepler_equation_solver_unit.sv
// Kepler equation solver top level: config register, sequencer and datapath.
// One Newton step runs a fold, 11 Horner terms on the shared multiplier and a restoring
// divider; the divider is skipped if the step clamps.
// done pulses one cycle; busy holds off start.
// Reset clears the sequencer and sets tolerance to 1.
`include "assert_macros.svh"
module kepler_equation_solver_unit #(
	parameter int MAX_ITERATIONS = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  kes_pkg::item_t   item,
	output logic             done,
	output kes_pkg::result_t result,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic [27:0]      tol_q;
	kes_pkg::cmd_t    cmd;
	kes_pkg::status_t status;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kes_pkg::TOL_INDEX) ? {4'b0, tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tol_q <= 28'd1;
		else if (psel && penable && pwrite && pready && (paddr[2] == kes_pkg::TOL_INDEX))
			tol_q <= pwdata[27:0];
	end

	kes_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	kes_datapath #(
		.MAX_ITERATIONS (MAX_ITERATIONS)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.item      (item),
		.tolerance (tol_q),
		.status    (status),
		.result    (result)
	);

	`KES_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted word did not raise busy")
	`KES_ASSERT(a_done_idle, done |=> !busy, "busy after result word")
	`KES_ASSERT_NEVER(a_done_unbusy, done && !busy, "result word while idle")

endmodule

### hw/rtl/kes_datapath.sv
// Datapath of the solver: fold, shared multiplier, Horner terms, divider, update.
module kes_datapath #(
	parameter int MAX_ITERATIONS = 30,
	localparam int CW = $clog2(MAX_ITERATIONS + 1)
) (
	input  logic             clk,
	input  kes_pkg::cmd_t    cmd,
	input  kes_pkg::item_t   item,
	input  logic [27:0]      tolerance,
	output kes_pkg::status_t status,
	output kes_pkg::result_t result
);

	logic signed [31:0] m_q, ea_q, s_q, c_q, es_q;
	logic [27:0]        e_q;
	logic signed [34:0] x_q;
	logic [1:0]         quad_q;
	logic [29:0]        y_q;
	logic [30:0]        t_q, sr_q, q_q;
	logic [31:0]        n_q, d_q, rem_q;
	logic signed [35:0] f_q;
	logic               big_q, conv_q;
	logic [CW-1:0]      cnt_q;
	logic [63:0]        prod_q;

	logic [34:0]        x_abs;
	logic [29:0]        a;
	logic               fold_hi, fold_lo;
	logic [31:0]        s_abs, c_abs, mul_a, mul_b;
	logic [31:0]        qe, qv;
	logic [7:0]         kc;
	logic [39:0]        qk, rr;
	logic signed [31:0] sr_e, sr_sig, cr_sig, ep_s, es_n, ec_n;
	logic signed [32:0] diff, d33;
	logic signed [35:0] f_n;
	logic [31:0]        d_n;
	logic [35:0]        mag;
	logic               big_n;
	logic [32:0]        sh, shd;
	logic               ge;
	logic [31:0]        qp2;
	logic [27:0]        dq;
	logic signed [33:0] ea_w, dq_s, ea_n;
	logic signed [31:0] ea_sat;
	logic [CW-1:0]      cnt_next;
	logic               conv_n;

	assign x_abs   = x_q[34] ? 35'(-x_q) : 35'(x_q);
	assign a       = x_abs[29:0];
	assign fold_hi = x_q > kes_pkg::QUARTER_PI;
	assign fold_lo = x_q < -kes_pkg::QUARTER_PI;
	assign s_abs   = s_q[31] ? 32'(-s_q) : 32'(s_q);
	assign c_abs   = c_q[31] ? 32'(-c_q) : 32'(c_q);

	always_comb begin
		case (cmd.mul_sel)
			kes_pkg::MUL_AA: begin mul_a = {2'b0, a};   mul_b = {2'b0, a}; end
			kes_pkg::MUL_YT: begin mul_a = {2'b0, y_q}; mul_b = {1'b0, t_q}; end
			kes_pkg::MUL_NR: begin
				mul_a = prod_q[61:30];
				mul_b = kes_pkg::horner_r(cmd.kidx);
			end
			kes_pkg::MUL_AT: begin mul_a = {2'b0, a};   mul_b = {1'b0, t_q}; end
			kes_pkg::MUL_ES: begin mul_a = {4'b0, e_q}; mul_b = s_abs; end
			kes_pkg::MUL_EC: begin mul_a = {4'b0, e_q}; mul_b = c_abs; end
			default:         begin mul_a = '0;          mul_b = '0; end
		endcase
	end

	// reciprocal quotient is low by at most one; one compare fixes it
	assign qe = prod_q[63:32];
	assign kc = kes_pkg::horner_k(cmd.kidx);
	assign qk = 40'(qe) * 40'(kc);
	assign rr = 40'(n_q) - qk;
	assign qv = qe + 32'(rr >= 40'(kc));

	assign sr_e   = $signed({1'b0, sr_q});
	assign sr_sig = x_q[34] ? -sr_e : sr_e;
	assign cr_sig = $signed({1'b0, t_q});

	assign ep_s = $signed({1'b0, prod_q[58:28]});
	assign es_n = s_q[31] ? -ep_s : ep_s;
	assign ec_n = c_q[31] ? -ep_s : ep_s;

	assign diff = $signed({ea_q[31], ea_q}) - $signed({m_q[31], m_q});
	assign f_n  = ($signed({{3{diff[32]}}, diff}) <<< 2) - $signed({{4{es_q[31]}}, es_q});
	assign d33  = $signed({2'b0, kes_pkg::ONE30}) - $signed({ec_n[31], ec_n});
	assign d_n  = (d33 < 33'sd1) ? 32'd1 : d33[31:0];

	assign mag   = f_q[35] ? 36'(-f_q) : 36'(f_q);
	assign big_n = (mag[35:33] != 3'd0) || (mag[32:0] >= {d_q, 1'b0});

	// restoring division: quotient bit per cycle
	assign sh  = {rem_q, cmd.div_first & f_q[0]};
	assign ge  = sh >= {1'b0, d_q};
	assign shd = sh - {1'b0, d_q};

	assign qp2 = {1'b0, q_q} + 32'd2;
	assign dq  = (big_q || (q_q > kes_pkg::Q_LIMIT)) ? kes_pkg::DQ_MAX : qp2[29:2];
	assign ea_w = $signed({{2{ea_q[31]}}, ea_q});
	assign dq_s = $signed({6'b0, dq});

	always_comb begin
		if (!f_q[35] && (f_q != 36'sd0))
			ea_n = ea_w - dq_s;
		else if (f_q[35])
			ea_n = ea_w + dq_s;
		else
			ea_n = ea_w;
		if (ea_n > 34'sd2147483647)
			ea_sat = 32'sh7fff_ffff;
		else if (ea_n < -34'sd2147483648)
			ea_sat = 32'sh8000_0000;
		else
			ea_sat = ea_n[31:0];
	end

	assign cnt_next = cnt_q + CW'(1);
	assign conv_n   = dq <= tolerance;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			m_q    <= item.mean_anomaly;
			ea_q   <= item.mean_anomaly;
			e_q    <= item.eccentricity;
			x_q    <= $signed({item.mean_anomaly[31], item.mean_anomaly, 2'b00});
			quad_q <= 2'd0;
			cnt_q  <= '0;
		end
		if (cmd.fold) begin
			if (fold_hi) begin
				x_q    <= x_q - kes_pkg::HALF_PI;
				quad_q <= quad_q + 2'd1;
			end else if (fold_lo) begin
				x_q    <= x_q + kes_pkg::HALF_PI;
				quad_q <= quad_q - 2'd1;
			end
		end
		if (cmd.mul_en)
			prod_q <= 64'(mul_a) * 64'(mul_b);
		if (cmd.lat_y) begin
			y_q <= prod_q[59:30];
			t_q <= kes_pkg::ONE30;
		end
		if (cmd.lat_n)
			n_q <= prod_q[61:30];
		if (cmd.hc)
			t_q <= kes_pkg::ONE30 - qv[30:0];
		if (cmd.lat_sr) begin
			sr_q <= prod_q[60:30];
			t_q  <= kes_pkg::ONE30;
		end
		if (cmd.quad) begin
			case (quad_q)
				2'd0:    begin s_q <= sr_sig;  c_q <= cr_sig; end
				2'd1:    begin s_q <= cr_sig;  c_q <= -sr_sig; end
				2'd2:    begin s_q <= -sr_sig; c_q <= -cr_sig; end
				default: begin s_q <= -cr_sig; c_q <= sr_sig; end
			endcase
		end
		if (cmd.lat_es)
			es_q <= es_n;
		if (cmd.lat_fd) begin
			f_q <= f_n;
			d_q <= d_n;
		end
		if (cmd.chk) begin
			big_q <= big_n;
			rem_q <= mag[32:1];
			q_q   <= '0;
		end
		if (cmd.div) begin
			rem_q <= ge ? shd[31:0] : sh[31:0];
			q_q   <= {q_q[29:0], ge};
		end
		if (cmd.upd) begin
			ea_q   <= ea_sat;
			x_q    <= $signed({ea_sat[31], ea_sat, 2'b00});
			quad_q <= 2'd0;
			cnt_q  <= cnt_next;
			conv_q <= conv_n;
		end
	end

	assign status.fold_done = !fold_hi && !fold_lo;
	assign status.big       = big_n;
	assign status.finish    = conv_n || (cnt_next == CW'(MAX_ITERATIONS));

	assign result.eccentric_anomaly = ea_q;
	assign result.step_count        = 5'(cnt_q);
	assign result.converged         = conv_q;

endmodule

### hw/rtl/kes_ctrl.sv
// Sequencer of the solver: walks each Newton step through the datapath.
module kes_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  kes_pkg::status_t status,
	output kes_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [16:0] {
		S_IDLE = 17'h00001,
		S_FOLD = 17'h00002,
		S_SQ   = 17'h00004,
		S_Y    = 17'h00008,
		S_HT   = 17'h00010,
		S_HN   = 17'h00020,
		S_HC   = 17'h00040,
		S_SF   = 17'h00080,
		S_SL   = 17'h00100,
		S_QUAD = 17'h00200,
		S_ES   = 17'h00400,
		S_EC   = 17'h00800,
		S_FD   = 17'h01000,
		S_CHK  = 17'h02000,
		S_DIV  = 17'h04000,
		S_UPD  = 17'h08000,
		S_OUT  = 17'h10000
	} state_t;

	state_t     state_q, state_n;
	logic [3:0] kidx_q, kidx_n;
	logic [4:0] divc_q, divc_n;

	always_comb begin
		state_n = state_q;
		kidx_n  = kidx_q;
		divc_n  = divc_q;
		cmd     = '0;
		cmd.kidx = kidx_q;
		cmd.mul_sel = kes_pkg::MUL_AA;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = S_FOLD;
				end
			end
			S_FOLD: begin
				cmd.fold = 1'b1;
				if (status.fold_done)
					state_n = S_SQ;
			end
			S_SQ: begin
				cmd.mul_en = 1'b1;
				state_n    = S_Y;
			end
			S_Y: begin
				cmd.lat_y = 1'b1;
				kidx_n    = kes_pkg::SIN_FIRST;
				state_n   = S_HT;
			end
			S_HT: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = kes_pkg::MUL_YT;
				state_n     = S_HN;
			end
			S_HN: begin
				cmd.lat_n   = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = kes_pkg::MUL_NR;
				state_n     = S_HC;
			end
			S_HC: begin
				cmd.hc = 1'b1;
				kidx_n = kidx_q + 4'd1;
				if (kidx_q == kes_pkg::SIN_LAST)
					state_n = S_SF;
				else if (kidx_q == kes_pkg::COS_LAST)
					state_n = S_QUAD;
				else
					state_n = S_HT;
			end
			S_SF: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = kes_pkg::MUL_AT;
				state_n     = S_SL;
			end
			S_SL: begin
				cmd.lat_sr = 1'b1;
				kidx_n     = kes_pkg::COS_FIRST;
				state_n    = S_HT;
			end
			S_QUAD: begin
				cmd.quad = 1'b1;
				state_n  = S_ES;
			end
			S_ES: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = kes_pkg::MUL_ES;
				state_n     = S_EC;
			end
			S_EC: begin
				cmd.lat_es  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = kes_pkg::MUL_EC;
				state_n     = S_FD;
			end
			S_FD: begin
				cmd.lat_fd = 1'b1;
				state_n    = S_CHK;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				divc_n  = '0;
				state_n = status.big ? S_UPD : S_DIV;
			end
			S_DIV: begin
				cmd.div       = 1'b1;
				cmd.div_first = divc_q == 5'd0;
				divc_n        = divc_q + 5'd1;
				if (divc_q == kes_pkg::DIV_LAST)
					state_n = S_UPD;
			end
			S_UPD: begin
				cmd.upd = 1'b1;
				state_n = status.finish ? S_OUT : S_FOLD;
			end
			S_OUT: begin
				state_n = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kidx_q  <= '0;
			divc_q  <= '0;
		end else begin
			state_q <= state_n;
			kidx_q  <= kidx_n;
			divc_q  <= divc_n;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;

endmodule

### tb/sv/testbench.sv
// Testbench for the Kepler equation solver: directed table, random items, bit-exact predictor.
`timescale 1ns / 1ps
module testbench;

	localparam int          MAX_STEPS  = 30;
	localparam logic [2:0]  TOL_ADDR   = {kes_pkg::TOL_INDEX, 2'b00};
	localparam logic [27:0] TOL_MAX    = 28'hFFF_FFFF;
	localparam int          IDLE_LIMIT = 50000;

	typedef struct {
		kes_pkg::item_t   word;
		bit               typed;
		kes_pkg::result_t want;
	} row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	kes_pkg::item_t   item = '0;
	logic             done;
	kes_pkg::result_t result;
	logic             psel = 1'b0;
	logic             penable = 1'b0;
	logic             pwrite = 1'b0;
	logic [2:0]       paddr = '0;
	logic [31:0]      pwdata = '0;
	logic [31:0]      prdata;
	logic             pready;

	kes_pkg::result_t pending_results[$];
	logic [27:0]      tol_shadow = 28'd1;
	int               errors = 0;
	int               words_sent = 0;
	int               words_checked = 0;
	int               unconverged = 0;
	int               idle_cycles = 0;

	kepler_equation_solver_unit #(.MAX_ITERATIONS(MAX_STEPS)) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// Horner evaluation; magnitude in Q.30, y = a^2
	function automatic longint unsigned horner(input longint unsigned a, input bit cosine);
		longint unsigned y, t;
		int k[6];
		int n;
		y = (a * a) >> 30;
		t = 64'd1 << 30;
		if (cosine) begin
			k = '{132, 90, 56, 30, 12, 2};
			n = 6;
		end else begin
			k = '{110, 72, 42, 20, 6, 1};
			n = 5;
		end
		for (int i = 0; i < n; i++)
			t = (64'd1 << 30) - ((y * t) >> 30) / longint'(k[i]);
		return cosine ? t : (a * t) >> 30;
	endfunction

	task automatic sin_cos_q30(input longint x, output longint s, output longint c);
		int quad;
		longint sr, cr;
		quad = 0;
		while (x > 64'sd843314856) begin x -= 64'sd1686629713; quad++; end
		while (x < -64'sd843314856) begin x += 64'sd1686629713; quad--; end
		sr = longint'(horner(x < 0 ? -x : x, 1'b0));
		cr = longint'(horner(x < 0 ? -x : x, 1'b1));
		if (x < 0)
			sr = -sr;
		case (quad & 3)
			0: begin s = sr;  c = cr;  end
			1: begin s = cr;  c = -sr; end
			2: begin s = -sr; c = -cr; end
			default: begin s = -cr; c = sr; end
		endcase
	endtask

	function automatic longint scale_by_ecc(input longint unsigned e, input longint v);
		longint r;
		r = longint'((e * longint'(v < 0 ? -v : v)) >> 28);
		return v < 0 ? -r : r;
	endfunction

	task automatic solve_kepler(input kes_pkg::item_t w, input logic [27:0] tol,
			output kes_pkg::result_t r);
		longint m, ea, s, c, f, d;
		longint unsigned e, mag, q, dq;
		int count;
		bit conv;
		m = longint'(w.mean_anomaly);
		e = longint'(w.eccentricity);
		ea = m;
		count = 0;
		conv = 0;
		do begin
			sin_cos_q30(ea * 4, s, c);
			f = (ea - m) * 4 - scale_by_ecc(e, s);
			d = (64'sd1 << 30) - scale_by_ecc(e, c);
			if (d < 1)
				d = 1;
			mag = f < 0 ? -f : f;
			if (mag >= (64'd1 << 33)) begin
				dq = 64'd1 << 27;
			end else begin
				q = (mag << 30) / longint'(d);
				dq = (q > (64'd1 << 29)) ? (64'd1 << 27) : (q + 2) >> 2;
			end
			if (f > 0)
				ea -= longint'(dq);
			else if (f < 0)
				ea += longint'(dq);
			if (ea > 64'sd2147483647)
				ea = 64'sd2147483647;
			if (ea < -64'sd2147483648)
				ea = -64'sd2147483648;
			count++;
			conv = (dq <= longint'(tol));
		end while (!conv && count < MAX_STEPS);
		r.eccentric_anomaly = ea[31:0];
		r.step_count = count[4:0];
		r.converged = conv;
	endtask

	// result checker
	always @(posedge clk) begin
		kes_pkg::result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result word", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.eccentric_anomaly !== want.eccentric_anomaly)
					report_mismatch("eccentric_anomaly", longint'(result.eccentric_anomaly),
						longint'(want.eccentric_anomaly));
				if (result.step_count !== want.step_count)
					report_mismatch("step_count", result.step_count, want.step_count);
				if (result.converged !== want.converged)
					report_mismatch("converged", result.converged, want.converged);
				if (!want.converged)
					unconverged++;
				words_checked++;
			end
		end
	end

	// watchdog on cycles without any accepted word, result word or register access
	always @(posedge clk) begin
		if ((start && !busy) || done || psel || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results pending", pending_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// start is left high when the next word follows back to back
	task automatic send_word(input kes_pkg::item_t w, input bit typed,
			input kes_pkg::result_t typed_want);
		kes_pkg::result_t want;
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item <= w;
		do @(posedge clk); while (busy);
		solve_kepler(w, tol_shadow, want);
		if (typed && want !== typed_want)
			report_mismatch("predictor vs table", longint'(want), longint'(typed_want));
		pending_results.push_back(want);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_tolerance(input logic [27:0] v);
		drain();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= TOL_ADDR; pwdata <= {4'b0, v};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0; penable <= 1'b0;
		tol_shadow = v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {4'b0, v})
			report_mismatch("tolerance readback", prdata, v);
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic kes_pkg::item_t random_word();
		kes_pkg::item_t w;
		int p;
		p = $urandom_range(99);
		if (p < 50)
			w.mean_anomaly = $urandom_range(32'd843314857, 0) - 32'sd421657428;
		else if (p < 60)
			w.mean_anomaly = $urandom_range(32'd100, 0) - 32'sd50;
		else
			w.mean_anomaly = $urandom;
		p = $urandom_range(99);
		if (p < 40)
			w.eccentricity = 28'($urandom);
		else if (p < 65)
			w.eccentricity = TOL_MAX - 28'($urandom_range(28'h0FF_FFFF, 0));
		else if (p < 85)
			w.eccentricity = 28'($urandom_range(28'h1F_FFFF, 0));
		else
			w.eccentricity = 28'($urandom_range(28'hFFF_FFFF, 28'hF00_0000) ^ $urandom_range(255));
		return w;
	endfunction

	task automatic random_phase(input int n);
		for (int i = 0; i < n; i++)
			send_word(random_word(), 1'b0, '0);
	endtask

	row_t directed[] = '{
		'{'{32'sd0, 28'd0}, 1'b1, '{32'sd0, 5'd1, 1'b1}},
		'{'{32'sd0, TOL_MAX}, 1'b1, '{32'sd0, 5'd1, 1'b1}},
		'{'{32'h7FFF_FFFF, 28'd0}, 1'b0, '0},
		'{'{32'h8000_0000, 28'd0}, 1'b0, '0},
		'{'{32'h7FFF_FFFF, TOL_MAX}, 1'b0, '0},
		'{'{32'h8000_0000, TOL_MAX}, 1'b0, '0},
		'{'{32'sd843314857, TOL_MAX}, 1'b0, '0},
		'{'{-32'sd843314857, TOL_MAX}, 1'b0, '0},
		'{'{32'sd1, 28'd1}, 1'b0, '0},
		'{'{-32'sd1, 28'h800_0000}, 1'b0, '0},
		'{'{32'sd268435456, 28'hF00_0000}, 1'b0, '0},
		'{'{32'h5555_5555, 28'h555_5555}, 1'b0, '0},
		'{'{32'hAAAA_AAAA, 28'hAAA_AAAA}, 1'b0, '0},
		'{'{32'sd12345678, 28'hFFF_FFF0}, 1'b0, '0}
	};

	initial begin
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (directed[i])
			send_word(directed[i].word, directed[i].typed, directed[i].want);
		set_tolerance(TOL_MAX);
		random_phase(40);
		set_tolerance(28'd0);
		foreach (directed[i])
			send_word(directed[i].word, 1'b0, '0);
		random_phase(20);
		for (int ph = 0; ph < 3; ph++) begin
			set_tolerance(28'($urandom_range(28'hFFFF, 0) << $urandom_range(12, 0)));
			random_phase(90);
		end
		set_tolerance(28'd1);
		random_phase(70);
		drain();
		$display("%0d words sent, %0d results checked, %0d hit the step limit",
			words_sent, words_checked, unconverged);
		$display("tolerance swept over zero, one, full scale and random values");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
